[sv/rci_pkg.sv]
// rci_pkg: constants, widths and stage payload types for the ray/circle pipeline
// depends on nothing; used by every rci module and the top level
package rci_pkg;

    localparam int FRAC_BITS = 16;

    localparam int M_W   = 33;                      // origin minus center
    localparam int BP_W  = 51;                      // one product of b
    localparam int B_W   = 52;                      // b = m.d
    localparam int MM_W  = 66;                      // m.m
    localparam int RR_W  = 62;                      // r*r
    localparam int BSQ_W = 2 * B_W;                 // b*b
    localparam int HALF  = B_W / 2;
    localparam int POS_W = ((BSQ_W > MM_W + 2 * FRAC_BITS) ? BSQ_W
                                                           : (MM_W + 2 * FRAC_BITS)) + 1;
    localparam int DIF_W = POS_W + 1;
    localparam int SQ_W  = (POS_W + 1) / 2;         // root bits
    localparam int DW    = 2 * SQ_W;                // padded radicand
    localparam int REM_W = SQ_W + 3;
    localparam int T_W   = ((B_W > SQ_W + 1) ? B_W : (SQ_W + 1)) + 2;
    localparam int TS_W  = T_W - FRAC_BITS;
    localparam int PQ_W  = 50;                      // dir times t
    localparam int Q_W   = 51;                      // hit point before clamp

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
    } t_geo;

    typedef struct packed {
        t_geo                   geo;
        logic signed [B_W-1:0]  b;
        logic [POS_W-1:0]       disc;
        logic                   miss;
    } t_fr2sq;

    typedef struct packed {
        t_geo                   geo;
        logic signed [B_W-1:0]  b;
        logic [SQ_W-1:0]        root;
        logic                   miss;
    } t_sq2bk;

endpackage

[sv/ray_circle_intersect.sv]
// ray_circle_intersect: top level of the fixed-point ray against circle pipeline
// depends on rci_pkg, rci_front, rci_sqrt, rci_back
//
// One query per cycle while the output is not stalled: each transfer on the
// input channel carries a ray origin, a direction and a circle in signed fixed
// point (rci_pkg::FRAC_BITS fraction bits) and gives exactly one result
// transfer, in order. There are eight front-end stages for m, b, m.m, r*r, b*b
// and the discriminant, one stage per root bit in the square root, and four
// back-end stages for t, its clamp, the hit point and the output register.
// Every stage holds its own valid bit and stalls only when the stage after it
// is full, so empty slots are squeezed out and new queries keep coming in while
// a finished result waits. On a miss all result fields are zero. t below zero
// (origin inside) becomes zero; t, hit_x and hit_y clamp to their ranges and
// raise saturated.
module ray_circle_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic signed [17:0]   i_dir_x,
    input  logic signed [17:0]   i_dir_y,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic [30:0]          i_radius,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [30:0]          o_t_distance,
    output logic signed [31:0]   o_hit_x,
    output logic signed [31:0]   o_hit_y,
    output logic                 o_saturated
);
    // front end to square root
    logic            w_fs_valid, w_fs_ready;
    rci_pkg::t_fr2sq w_fs_data;

    // square root to back end
    logic            w_sb_valid, w_sb_ready;
    rci_pkg::t_sq2bk w_sb_data;

    rci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_valid    (w_fs_valid),
        .i_ready    (w_fs_ready),
        .o_data     (w_fs_data)
    );

    // bit-per-stage root of the discriminant
    rci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fs_valid),
        .o_ready (w_fs_ready),
        .i_data  (w_fs_data),
        .o_valid (w_sb_valid),
        .i_ready (w_sb_ready),
        .o_data  (w_sb_data)
    );

    // last stage of the back end is the output register
    rci_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_sb_valid),
        .o_ready      (w_sb_ready),
        .i_data       (w_sb_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_t_distance (o_t_distance),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y),
        .o_saturated  (o_saturated)
    );

endmodule

[sv/rci_front.sv]
// rci_front: eight-stage front end, m, b, m.m, r*r, b*b and the discriminant
// depends on rci_pkg
module rci_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_origin_x,
    input  logic signed [31:0]    i_origin_y,
    input  logic signed [17:0]    i_dir_x,
    input  logic signed [17:0]    i_dir_y,
    input  logic signed [31:0]    i_center_x,
    input  logic signed [31:0]    i_center_y,
    input  logic [30:0]           i_radius,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rci_pkg::t_fr2sq       o_data
);
    localparam int NS = 8;
    localparam int F  = rci_pkg::FRAC_BITS;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    rci_pkg::t_geo r_geo [0:NS-1];

    logic signed [rci_pkg::M_W-1:0]  r_mx0, r_my0;
    logic [30:0]                     r_rad0;
    logic signed [rci_pkg::BP_W-1:0] r_bx1, r_by1;
    logic [rci_pkg::MM_W-1:0]        r_mxx1, r_myy1, r_mm2, r_mm3, r_mm4, r_mm5, r_mm6;
    logic [rci_pkg::RR_W-1:0]        r_rr1, r_rr2, r_rr3, r_rr4, r_rr5;
    logic signed [rci_pkg::B_W-1:0]  r_b2, r_b3, r_b4, r_b5, r_b6, r_b7;
    logic                            r_away3, r_away4, r_away5, r_away6, r_miss7;
    logic [rci_pkg::B_W-1:0]         r_babs3;
    logic [rci_pkg::B_W-1:0]         r_ll4, r_lh4, r_hh4;
    logic [rci_pkg::BSQ_W-1:0]       r_bsq5;
    logic [rci_pkg::POS_W-1:0]       r_pos6, r_disc7;

    logic [rci_pkg::M_W-1:0]   w_mxa, w_mya;
    logic [rci_pkg::DIF_W-1:0] w_dif;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_mxa = r_mx0[rci_pkg::M_W-1] ? rci_pkg::M_W'(-r_mx0) : rci_pkg::M_W'(r_mx0);
    assign w_mya = r_my0[rci_pkg::M_W-1] ? rci_pkg::M_W'(-r_my0) : rci_pkg::M_W'(r_my0);

    // borrow of pos - neg marks a negative discriminant
    assign w_dif = {1'b0, r_pos6}
                 - rci_pkg::DIF_W'({r_mm6, {(2 * F){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_geo[0] <= '{px: i_origin_x, py: i_origin_y, dx: i_dir_x, dy: i_dir_y};
            r_mx0    <= $signed({i_origin_x[31], i_origin_x}) - $signed({i_center_x[31], i_center_x});
            r_my0    <= $signed({i_origin_y[31], i_origin_y}) - $signed({i_center_y[31], i_center_y});
            r_rad0   <= i_radius;
        end
        if (w_rdy[1]) begin
            r_geo[1] <= r_geo[0];
            r_bx1    <= r_mx0 * r_geo[0].dx;
            r_by1    <= r_my0 * r_geo[0].dy;
            r_mxx1   <= w_mxa * w_mxa;
            r_myy1   <= w_mya * w_mya;
            r_rr1    <= r_rad0 * r_rad0;
        end
        if (w_rdy[2]) begin
            r_geo[2] <= r_geo[1];
            r_b2     <= $signed({r_bx1[rci_pkg::BP_W-1], r_bx1})
                      + $signed({r_by1[rci_pkg::BP_W-1], r_by1});
            r_mm2    <= r_mxx1 + r_myy1;
            r_rr2    <= r_rr1;
        end
        if (w_rdy[3]) begin
            r_geo[3] <= r_geo[2];
            // origin outside and pointing away
            r_away3  <= (r_mm2 > rci_pkg::MM_W'(r_rr2)) && !r_b2[rci_pkg::B_W-1] && (r_b2 != '0);
            r_babs3  <= r_b2[rci_pkg::B_W-1] ? rci_pkg::B_W'(-r_b2) : rci_pkg::B_W'(r_b2);
            r_mm3    <= r_mm2;
            r_rr3    <= r_rr2;
            r_b3     <= r_b2;
        end
        if (w_rdy[4]) begin
            r_geo[4] <= r_geo[3];
            r_ll4    <= r_babs3[rci_pkg::HALF-1:0] * r_babs3[rci_pkg::HALF-1:0];
            r_lh4    <= r_babs3[rci_pkg::HALF-1:0] * r_babs3[rci_pkg::B_W-1:rci_pkg::HALF];
            r_hh4    <= r_babs3[rci_pkg::B_W-1:rci_pkg::HALF]
                      * r_babs3[rci_pkg::B_W-1:rci_pkg::HALF];
            r_mm4    <= r_mm3;
            r_rr4    <= r_rr3;
            r_b4     <= r_b3;
            r_away4  <= r_away3;
        end
        if (w_rdy[5]) begin
            r_geo[5] <= r_geo[4];
            // cross term appears twice, hence the extra shift
            r_bsq5   <= {r_hh4, {rci_pkg::B_W{1'b0}}}
                      + rci_pkg::BSQ_W'({r_lh4, {(rci_pkg::HALF + 1){1'b0}}})
                      + rci_pkg::BSQ_W'(r_ll4);
            r_mm5    <= r_mm4;
            r_rr5    <= r_rr4;
            r_b5     <= r_b4;
            r_away5  <= r_away4;
        end
        if (w_rdy[6]) begin
            r_geo[6] <= r_geo[5];
            r_pos6   <= rci_pkg::POS_W'(r_bsq5)
                      + rci_pkg::POS_W'({r_rr5, {(2 * F){1'b0}}});
            r_mm6    <= r_mm5;
            r_b6     <= r_b5;
            r_away6  <= r_away5;
        end
        if (w_rdy[7]) begin
            r_geo[7] <= r_geo[6];
            r_miss7  <= r_away6 || w_dif[rci_pkg::DIF_W-1];
            r_disc7  <= w_dif[rci_pkg::POS_W-1:0];
            r_b7     <= r_b6;
        end
    end

    assign o_data = '{geo: r_geo[NS-1], b: r_b7, disc: r_disc7, miss: r_miss7};

endmodule

[sv/rci_sqrt.sv]
// rci_sqrt: floored square root of the discriminant, one root bit per stage
// depends on rci_pkg
module rci_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rci_pkg::t_fr2sq  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rci_pkg::t_sq2bk  o_data
);
    localparam int NS = rci_pkg::SQ_W;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    logic [rci_pkg::REM_W-1:0]      r_rem  [0:NS-1];
    logic [rci_pkg::SQ_W-1:0]       r_root [0:NS-1];
    logic [rci_pkg::DW-1:0]         r_dsh  [0:NS-1];
    rci_pkg::t_geo                  r_geo  [0:NS-1];
    logic signed [rci_pkg::B_W-1:0] r_b    [0:NS-1];
    logic                           r_miss [0:NS-1];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [rci_pkg::REM_W-1:0]      w_rp, w_remx, w_trial;
        logic [rci_pkg::SQ_W-1:0]       w_rtp;
        logic [rci_pkg::DW-1:0]         w_dp;
        rci_pkg::t_geo                  w_geo;
        logic signed [rci_pkg::B_W-1:0] w_b;
        logic                           w_miss, w_ge;

        if (k == 0) begin : g_first
            assign w_rp   = '0;
            assign w_rtp  = '0;
            assign w_dp   = rci_pkg::DW'(i_data.disc);
            assign w_geo  = i_data.geo;
            assign w_b    = i_data.b;
            assign w_miss = i_data.miss;
        end else begin : g_next
            assign w_rp   = r_rem[k-1];
            assign w_rtp  = r_root[k-1];
            assign w_dp   = r_dsh[k-1];
            assign w_geo  = r_geo[k-1];
            assign w_b    = r_b[k-1];
            assign w_miss = r_miss[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign w_remx  = {w_rp[rci_pkg::REM_W-3:0], w_dp[rci_pkg::DW-1:rci_pkg::DW-2]};
        assign w_trial = rci_pkg::REM_W'({w_rtp, 2'b01});
        assign w_ge    = (w_remx >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= w_ge ? (w_remx - w_trial) : w_remx;
                r_root[k] <= {w_rtp[rci_pkg::SQ_W-2:0], w_ge};
                r_dsh[k]  <= {w_dp[rci_pkg::DW-3:0], 2'b00};
                r_geo[k]  <= w_geo;
                r_b[k]    <= w_b;
                r_miss[k] <= w_miss;
            end
        end
    end

    assign o_data = '{geo: r_geo[NS-1], b: r_b[NS-1], root: r_root[NS-1],
                      miss: r_miss[NS-1]};

endmodule

[sv/rci_back.sv]
// rci_back: four-stage back end, t, its clamp, the hit point and the output register
// depends on rci_pkg
module rci_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rci_pkg::t_sq2bk      i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [30:0]          o_t_distance,
    output logic signed [31:0]   o_hit_x,
    output logic signed [31:0]   o_hit_y,
    output logic                 o_saturated
);
    localparam int NS = 4;
    localparam int F  = rci_pkg::FRAC_BITS;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    rci_pkg::t_geo                   r_geo0, r_geo1, r_geo2;
    logic                            r_miss0, r_miss1, r_miss2;
    logic signed [rci_pkg::T_W-1:0]  r_t0;
    logic [30:0]                     r_tq1, r_tq2;
    logic                            r_sat1, r_sat2;
    logic signed [rci_pkg::PQ_W-1:0] r_qx2, r_qy2;
    logic                            r_hit, r_sat;
    logic [30:0]                     r_t;
    logic signed [31:0]              r_hx, r_hy;

    logic [rci_pkg::T_W-1:0]         w_tnn;
    logic [rci_pkg::TS_W-1:0]        w_tsh;
    logic                            w_tovf;
    logic signed [rci_pkg::Q_W-1:0]  w_sx, w_sy;
    logic                            w_ovx, w_unx, w_ovy, w_uny;
    logic signed [31:0]              w_cx, w_cy;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // negative t clamps to zero, then drop fraction bits
    assign w_tnn  = r_t0[rci_pkg::T_W-1] ? '0 : rci_pkg::T_W'(r_t0);
    assign w_tsh  = w_tnn[rci_pkg::T_W-1:F];
    assign w_tovf = |w_tsh[rci_pkg::TS_W-1:31];

    // arithmetic shift gives floor of d*t
    assign w_sx = $signed(rci_pkg::Q_W'(r_geo2.px)) + rci_pkg::Q_W'(r_qx2 >>> F);
    assign w_sy = $signed(rci_pkg::Q_W'(r_geo2.py)) + rci_pkg::Q_W'(r_qy2 >>> F);

    assign w_ovx = !w_sx[rci_pkg::Q_W-1] && (|w_sx[rci_pkg::Q_W-2:31]);
    assign w_unx =  w_sx[rci_pkg::Q_W-1] && !(&w_sx[rci_pkg::Q_W-2:31]);
    assign w_ovy = !w_sy[rci_pkg::Q_W-1] && (|w_sy[rci_pkg::Q_W-2:31]);
    assign w_uny =  w_sy[rci_pkg::Q_W-1] && !(&w_sy[rci_pkg::Q_W-2:31]);

    assign w_cx = w_ovx ? 32'sh7fffffff : (w_unx ? 32'sh80000000 : w_sx[31:0]);
    assign w_cy = w_ovy ? 32'sh7fffffff : (w_uny ? 32'sh80000000 : w_sy[31:0]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_geo0  <= i_data.geo;
            r_miss0 <= i_data.miss;
            r_t0    <= -$signed(rci_pkg::T_W'(i_data.b))
                     - $signed(rci_pkg::T_W'({1'b0, i_data.root}));
        end
        if (w_rdy[1]) begin
            r_geo1  <= r_geo0;
            r_miss1 <= r_miss0;
            r_tq1   <= w_tovf ? 31'h7fffffff : w_tsh[30:0];
            r_sat1  <= w_tovf;
        end
        if (w_rdy[2]) begin
            r_geo2  <= r_geo1;
            r_miss2 <= r_miss1;
            r_tq2   <= r_tq1;
            r_sat2  <= r_sat1;
            r_qx2   <= r_geo1.dx * $signed({1'b0, r_tq1});
            r_qy2   <= r_geo1.dy * $signed({1'b0, r_tq1});
        end
        if (w_rdy[3]) begin
            r_hit <= !r_miss2;
            r_t   <= r_miss2 ? '0 : r_tq2;
            r_hx  <= r_miss2 ? '0 : w_cx;
            r_hy  <= r_miss2 ? '0 : w_cy;
            r_sat <= !r_miss2 && (r_sat2 || w_ovx || w_unx || w_ovy || w_uny);
        end
    end

    assign o_hit        = r_hit;
    assign o_t_distance = r_t;
    assign o_hit_x      = r_hx;
    assign o_hit_y      = r_hy;
    assign o_saturated  = r_sat;

endmodule
